### rtl/rds_pkg.sv
// Shared types, constants and command/status structures of the RDS group decoder.
package rds_pkg;

  localparam int TEXT_CHARS = 64;
  localparam int NAME_CHARS = 8;
  localparam int TEXT_AW    = $clog2(TEXT_CHARS);
  localparam int NAME_BITS  = NAME_CHARS * 8;

  localparam logic [3:0] GRP_BASIC     = 4'h0;
  localparam logic [3:0] GRP_RADIOTEXT = 4'h2;
  localparam logic [1:0] ERR_UNCORR    = 2'd3;
  localparam logic [1:0] ERR_MAX_B     = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] block_a;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic [1:0]  err_a;
    logic [1:0]  err_b;
    logic [1:0]  err_d;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] program_id;
    logic [4:0]  program_type;
    logic [1:0]  text_kind;
    logic [5:0]  char_pos;
    logic [7:0]  char_value;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_HI,
    OUT_LO,
    OUT_NAME,
    OUT_TEXT
  } out_sel_t;

  typedef struct packed {
    logic     take;
    logic     name_shift;
    logic     name_load;
    logic     name_sel_mid;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     rd_issue;
    logic     text_upd;
    logic     text_wr;
    logic     out_load;
    out_sel_t out_sel;
  } rds_cmd_t;

  typedef struct packed {
    logic       acc;
    logic       grp0;
    logic       grp2a;
    logic       ed_ok;
    logic       stream;
    logic       name_p3;
    logic       win_new;
    logic       win_mid;
    logic       publish;
    logic       out_free;
    logic       pend;
    logic       rd_all;
    logic [5:0] cnt;
  } rds_status_t;

endpackage

### rtl/rds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rds_ctrl.sv
// Controller state machine of the RDS group decoder.
module rds_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rds_pkg::rds_status_t sts,
  output rds_pkg::rds_cmd_t    cmd
);
  import rds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_VOTE,
    S_NONE,
    S_HI,
    S_LO,
    S_NAME,
    S_PUB,
    S_TEXT_UPD,
    S_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   pub_r, pub_nxt;
  logic   pub_load;

  always_comb begin
    state_nxt = state_r;
    pub_nxt   = pub_r;
    cmd       = '0;
    cmd.out_sel = OUT_NONE;
    pub_load  = sts.pend & sts.out_free;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.acc) begin
          state_nxt = S_NONE;
        end else if (sts.grp0) begin
          if (!sts.ed_ok) begin
            state_nxt = S_NONE;
          end else if (sts.stream) begin
            state_nxt = S_HI;
          end else begin
            cmd.name_shift = 1'b1;
            state_nxt = sts.name_p3 ? S_VOTE : S_NONE;
          end
        end else if (sts.grp2a) begin
          pub_nxt = sts.publish;
          if (sts.publish) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_PUB;
          end else begin
            state_nxt = S_TEXT_UPD;
          end
        end else begin
          state_nxt = S_NONE;
        end
      end
      S_VOTE: begin
        if (sts.win_new || sts.win_mid) begin
          cmd.name_load    = 1'b1;
          cmd.name_sel_mid = ~sts.win_new;
          cmd.cnt_clr      = 1'b1;
          state_nxt        = S_NAME;
        end else begin
          state_nxt = S_NONE;
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_NONE;
          state_nxt    = S_IDLE;
        end
      end
      S_HI: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_HI;
          state_nxt    = S_LO;
        end
      end
      S_LO: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_LO;
          state_nxt    = S_IDLE;
        end
      end
      S_NAME: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_NAME;
          cmd.cnt_inc  = 1'b1;
          if (sts.cnt[2:0] == 3'd7) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PUB: begin
        cmd.out_sel  = OUT_TEXT;
        cmd.out_load = pub_load;
        cmd.cnt_inc  = pub_load;
        cmd.rd_issue = ~sts.rd_all & (~sts.pend | pub_load);
        if (pub_load && sts.cnt == 6'(TEXT_CHARS - 1)) begin
          state_nxt = S_TEXT_UPD;
        end
      end
      S_TEXT_UPD: begin
        cmd.text_upd = 1'b1;
        cmd.cnt_clr  = 1'b1;
        state_nxt    = S_WRITE;
      end
      S_WRITE: begin
        cmd.text_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt[1:0] == 2'd3) begin
          state_nxt = pub_r ? S_IDLE : S_NONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pub_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pub_r   <= pub_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### rtl/rds_dp.sv
// Datapath of the RDS group decoder: held codes, name copies, text store and output register.
module rds_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rds_pkg::in_item_t    in_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  rds_pkg::rds_cmd_t    cmd,
  output rds_pkg::rds_status_t sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rds_pkg::out_item_t   out_data
);
  import rds_pkg::*;

  in_item_t               item_r;
  logic                   stream_r;
  logic [15:0]            held_pi_r;
  logic [4:0]             held_pty_r;
  logic [NAME_BITS-1:0]   newest_r, newest_nxt;
  logic [NAME_BITS-1:0]   middle_r, middle_nxt;
  logic [NAME_BITS-1:0]   oldest_r, oldest_nxt;
  logic [NAME_BITS-1:0]   name_sr_r;
  logic [TEXT_CHARS-1:0]  valid_r, valid_nxt;
  logic [TEXT_AW-1:0]     last_pos_r;
  logic                   prev_ab_r;
  logic [5:0]             cnt_r;
  logic [TEXT_AW:0]       rd_ptr_r;
  logic                   pend_r;
  logic                   rvalid_r;
  logic                   out_valid_r;
  out_item_t              out_data_r, out_data_nxt;

  logic                   clear_all;
  logic [1:0]             pair;
  logic [5:0]             pair_base;
  logic [TEXT_AW-1:0]     seg_pos;
  logic [TEXT_AW-1:0]     wr_addr;
  logic [7:0]             wr_byte;
  logic [7:0]             ram_rdata;
  logic [7:0]             text_char;
  logic                   text_load;

  assign clear_all = (cmd.take & in_data.action) | cfg_wr_en;
  assign pair      = item_r.block_b[1:0];
  assign pair_base = {pair, 4'b0000};
  assign seg_pos   = {item_r.block_b[3:0], 2'b00};
  assign wr_addr   = {item_r.block_b[3:0], cnt_r[1:0]};
  assign text_load = cmd.out_load & (cmd.out_sel == OUT_TEXT);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    wr_byte = item_r.block_c[15:8];
      2'd1:    wr_byte = item_r.block_c[7:0];
      2'd2:    wr_byte = item_r.block_d[15:8];
      default: wr_byte = item_r.block_d[7:0];
    endcase
  end

  rds_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_CHARS)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (cmd.text_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_ptr_r[TEXT_AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign text_char = rvalid_r ? ram_rdata : 8'd0;

  always_comb begin
    newest_nxt = newest_r;
    middle_nxt = middle_r;
    oldest_nxt = oldest_r;
    if (cmd.name_shift) begin
      oldest_nxt[pair_base +: 16] = middle_r[pair_base +: 16];
      middle_nxt[pair_base +: 16] = newest_r[pair_base +: 16];
      newest_nxt[pair_base +: 16] = {item_r.block_d[7:0], item_r.block_d[15:8]};
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.text_upd && (item_r.block_b[4] != prev_ab_r)) begin
      valid_nxt = '0;
    end
    if (cmd.text_wr) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    out_data_nxt.accepted     = sts.acc;
    out_data_nxt.program_id   = held_pi_r;
    out_data_nxt.program_type = held_pty_r;
    out_data_nxt.text_kind    = KIND_NONE;
    out_data_nxt.char_pos     = '0;
    out_data_nxt.char_value   = '0;
    out_data_nxt.last         = 1'b1;
    case (cmd.out_sel)
      OUT_NONE: begin
      end
      OUT_HI: begin
        out_data_nxt.text_kind  = KIND_NAME;
        out_data_nxt.char_pos   = {3'b000, pair, 1'b0};
        out_data_nxt.char_value = item_r.block_d[15:8];
        out_data_nxt.last       = 1'b0;
      end
      OUT_LO: begin
        out_data_nxt.text_kind  = KIND_NAME;
        out_data_nxt.char_pos   = {3'b000, pair, 1'b1};
        out_data_nxt.char_value = item_r.block_d[7:0];
      end
      OUT_NAME: begin
        out_data_nxt.text_kind  = KIND_NAME;
        out_data_nxt.char_pos   = cnt_r;
        out_data_nxt.char_value = name_sr_r[7:0];
        out_data_nxt.last       = (cnt_r[2:0] == 3'd7);
      end
      OUT_TEXT: begin
        out_data_nxt.text_kind  = KIND_TEXT;
        out_data_nxt.char_pos   = cnt_r;
        out_data_nxt.char_value = text_char;
        out_data_nxt.last       = (cnt_r == 6'(TEXT_CHARS - 1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_data;
    end
    if (cmd.name_load) begin
      name_sr_r <= cmd.name_sel_mid ? middle_r : newest_r;
    end else if (cmd.out_load && (cmd.out_sel == OUT_NAME)) begin
      name_sr_r <= {8'd0, name_sr_r[NAME_BITS-1:8]};
    end
    if (cmd.rd_issue) begin
      rvalid_r <= valid_r[rd_ptr_r[TEXT_AW-1:0]];
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_r    <= 1'b0;
      held_pi_r   <= '0;
      held_pty_r  <= '0;
      newest_r    <= '0;
      middle_r    <= '0;
      oldest_r    <= '0;
      valid_r     <= '0;
      last_pos_r  <= '0;
      prev_ab_r   <= 1'b0;
      cnt_r       <= '0;
      rd_ptr_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stream_r <= cfg_wr_data;
      end
      if (clear_all) begin
        held_pi_r  <= '0;
        held_pty_r <= '0;
        newest_r   <= '0;
        middle_r   <= '0;
        oldest_r   <= '0;
        valid_r    <= '0;
        last_pos_r <= '0;
        prev_ab_r  <= 1'b0;
      end else begin
        if (cmd.take) begin
          if (in_data.err_a != ERR_UNCORR) begin
            held_pi_r <= in_data.block_a;
          end
          if (in_data.err_b <= ERR_MAX_B) begin
            held_pty_r <= in_data.block_b[9:5];
          end
        end
        newest_r <= newest_nxt;
        middle_r <= middle_nxt;
        oldest_r <= oldest_nxt;
        valid_r  <= valid_nxt;
        if (cmd.text_upd) begin
          last_pos_r <= seg_pos;
          prev_ab_r  <= item_r.block_b[4];
        end
      end
      if (cmd.cnt_clr) begin
        cnt_r    <= '0;
        rd_ptr_r <= '0;
        pend_r   <= 1'b0;
      end else begin
        if (cmd.cnt_inc) begin
          cnt_r <= cnt_r + 6'd1;
        end
        if (cmd.rd_issue) begin
          rd_ptr_r <= rd_ptr_r + (TEXT_AW + 1)'(1);
        end
        pend_r <= cmd.rd_issue | (pend_r & ~text_load);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.acc      = ~item_r.action & (item_r.err_b <= ERR_MAX_B);
    sts.grp0     = (item_r.block_b[15:12] == GRP_BASIC);
    sts.grp2a    = (item_r.block_b[15:12] == GRP_RADIOTEXT) & ~item_r.block_b[11];
    sts.ed_ok    = (item_r.err_d != ERR_UNCORR);
    sts.stream   = stream_r;
    sts.name_p3  = (pair == 2'd3);
    sts.win_new  = (newest_r == middle_r) | (newest_r == oldest_r);
    sts.win_mid  = (middle_r == oldest_r);
    sts.publish  = (seg_pos < last_pos_r);
    sts.out_free = ~out_valid_r | ~out_stall;
    sts.pend     = pend_r;
    sts.rd_all   = rd_ptr_r[TEXT_AW];
    sts.cnt      = cnt_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/rds_group_decoder.sv
// Top level of the RDS group decoder: controller, datapath and text store.
//
// The input channel takes one item at a time: a received group (blocks A to D
// with error levels) or a clear command. in_stall stays high from the
// transfer until the controller has finished the item.
// Each item gives one or more results on the output channel; the final one
// carries last. A plain group gives one result. Station-name output takes
// two or eight results, one per cycle while the output is free. A radiotext
// publication streams 64 stored characters at one per cycle while the output
// is free, set by the single read port of the text RAM, then writes the new
// characters. A radiotext group that publishes nothing writes them too.
// A result waits in the output register while out_stall is high, and the
// controller holds its sequence until the register is free.
// The configuration write sets stream mode and clears all decoded data.
// Reset, a clear command and a configuration write clear all decoded data.
module rds_group_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rds_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rds_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import rds_pkg::*;

  rds_cmd_t    cmd;
  rds_status_t sts;

  rds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rds_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### tb/sv/rds_group_decoder_test.sv
// Self-checking testbench of the RDS group decoder: directed and random groups against a scoreboard.
module rds_group_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rds_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;

  logic            stream_mode;
  logic [15:0]     pi_held;
  logic [4:0]      pty_held;
  logic [7:0][7:0] name_newest;
  logic [7:0][7:0] name_middle;
  logic [7:0][7:0] name_oldest;
  logic [7:0]      text_store [TEXT_CHARS];
  logic [5:0]      text_pos_prev;
  logic            ab_prev;
  out_item_t       pending_results [$];

  bit idling          = 1'b1;
  int holdoff_request = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;

  rds_group_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_text();
    for (int k = 0; k < TEXT_CHARS; k++) text_store[6'(k)] = '0;
  endfunction

  function automatic void clear_decoded();
    pi_held       = '0;
    pty_held      = '0;
    name_newest   = '0;
    name_middle   = '0;
    name_oldest   = '0;
    text_pos_prev = '0;
    ab_prev       = 1'b0;
    clear_text();
  endfunction

  function automatic void push_char(logic acc, logic [1:0] kind, logic [5:0] pos,
                                    logic [7:0] val);
    out_item_t r;
    r.accepted     = acc;
    r.program_id   = pi_held;
    r.program_type = pty_held;
    r.text_kind    = kind;
    r.char_pos     = pos;
    r.char_value   = val;
    r.last         = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_decode(in_item_t it);
    int              base;
    logic            acc;
    logic [5:0]      slot;
    logic [2:0]      nidx;
    logic [7:0][7:0] winner;
    bit              have_winner;
    out_item_t       tail;
    base        = pending_results.size();
    acc         = 1'b0;
    have_winner = 1'b0;
    winner      = '0;
    if (it.action) begin
      clear_decoded();
    end else begin
      if (it.err_a != ERR_UNCORR) pi_held = it.block_a;
      if (it.err_b <= ERR_MAX_B) begin
        acc      = 1'b1;
        pty_held = it.block_b[9:5];
        if (it.block_b[15:12] == GRP_BASIC) begin
          if (it.err_d != ERR_UNCORR) begin
            slot = {3'b000, it.block_b[1:0], 1'b0};
            nidx = {it.block_b[1:0], 1'b0};
            if (stream_mode) begin
              push_char(acc, KIND_NAME, slot, it.block_d[15:8]);
              push_char(acc, KIND_NAME, slot + 6'd1, it.block_d[7:0]);
            end else begin
              for (int k = 0; k < 2; k++) begin
                name_oldest[nidx + 3'(k)] = name_middle[nidx + 3'(k)];
                name_middle[nidx + 3'(k)] = name_newest[nidx + 3'(k)];
              end
              name_newest[nidx]        = it.block_d[15:8];
              name_newest[nidx + 3'd1] = it.block_d[7:0];
              if (slot == 6'd6) begin
                if (name_newest == name_middle || name_newest == name_oldest) begin
                  winner      = name_newest;
                  have_winner = 1'b1;
                end else if (name_middle == name_oldest) begin
                  winner      = name_middle;
                  have_winner = 1'b1;
                end
              end
              if (have_winner) begin
                for (int k = 0; k < NAME_CHARS; k++) begin
                  push_char(acc, KIND_NAME, 6'(k), winner[3'(k)]);
                end
              end
            end
          end
        end else if (it.block_b[15:12] == GRP_RADIOTEXT && !it.block_b[11]) begin
          slot = {it.block_b[3:0], 2'b00};
          if (slot < text_pos_prev) begin
            for (int k = 0; k < TEXT_CHARS; k++) begin
              push_char(acc, KIND_TEXT, 6'(k), text_store[6'(k)]);
            end
          end
          text_pos_prev = slot;
          if (it.block_b[4] != ab_prev) begin
            ab_prev = it.block_b[4];
            clear_text();
          end
          text_store[slot]        = it.block_c[15:8];
          text_store[slot + 6'd1] = it.block_c[7:0];
          text_store[slot + 6'd2] = it.block_d[15:8];
          text_store[slot + 6'd3] = it.block_d[7:0];
        end
      end
    end
    if (pending_results.size() == base) push_char(acc, KIND_NONE, 6'd0, 8'd0);
    tail      = pending_results.pop_back();
    tail.last = 1'b1;
    pending_results.push_back(tail);
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result %h arrived with no expectation waiting", got);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("accepted", 16'(want.accepted), 16'(got.accepted));
      check_field("program_id", want.program_id, got.program_id);
      check_field("program_type", 16'(want.program_type), 16'(got.program_type));
      check_field("text_kind", 16'(want.text_kind), 16'(got.text_kind));
      check_field("char_pos", 16'(want.char_pos), 16'(got.char_pos));
      check_field("char_value", 16'(want.char_value), 16'(got.char_value));
      check_field("last", 16'(want.last), 16'(got.last));
    end
  endfunction

  function automatic in_item_t make_group(logic [3:0] gtype, logic ver, logic ab,
                                          logic [3:0] seg, logic [15:0] c, logic [15:0] d);
    in_item_t it;
    it         = '0;
    it.block_a = {12'hC0A, 4'($urandom)};
    it.block_b = {gtype, ver, 1'($urandom), 5'($urandom), ab, seg};
    it.block_c = c;
    it.block_d = d;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_decode(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_stream_mode(logic mode);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    stream_mode = mode;
    clear_decoded();
  endtask

  task automatic test_program_fields();
    in_item_t it;
    it        = '1;
    send_item(it);
    it        = make_group(4'hF, 1'b1, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF);
    it.block_a = 16'hFFFF;
    send_item(it);
    it        = make_group(4'h7, 1'b0, 1'b0, 4'h0, 16'h0000, 16'h0000);
    it.block_a = 16'h1234;
    it.err_a  = ERR_UNCORR;
    send_item(it);
    it        = make_group(4'h1, 1'b0, 1'b0, 4'h3, 16'h0000, 16'h0000);
    it.block_b = 16'h13E0;
    it.err_b  = ERR_UNCORR;
    send_item(it);
    it        = make_group(GRP_RADIOTEXT, 1'b1, 1'b1, 4'h5, 16'hA5A5, 16'h5A5A);
    it.err_b  = ERR_MAX_B;
    send_item(it);
    it        = make_group(4'h4, 1'b0, 1'b0, 4'h0, 16'h0000, 16'h0000);
    it.block_a = 16'h0000;
    it.err_a  = 2'd2;
    send_item(it);
  endtask

  task automatic test_name_voting();
    logic [63:0] station;
    in_item_t    it;
    station = "RADIO 1 ";
    for (int pass = 0; pass < 2; pass++) begin
      for (int seg = 0; seg < 4; seg++) begin
        it = make_group(GRP_BASIC, 1'b0, 1'b0, 4'(seg), 16'h0000, station[63 - 16 * seg -: 16]);
        it.err_d = 2'(seg % 3);
        send_item(it);
      end
    end
    it        = make_group(GRP_BASIC, 1'b0, 1'b0, 4'h0, 16'h0000, 16'hFFFF);
    it.err_d  = ERR_UNCORR;
    send_item(it);
  endtask

  task automatic test_radiotext();
    send_item(make_group(GRP_RADIOTEXT, 1'b0, 1'b0, 4'd0, "He", "ll"));
    send_item(make_group(GRP_RADIOTEXT, 1'b0, 1'b0, 4'd1, "o ", "wo"));
    send_item(make_group(GRP_RADIOTEXT, 1'b0, 1'b0, 4'd15, 16'hFFFF, 16'hFFFF));
    send_item(make_group(GRP_RADIOTEXT, 1'b0, 1'b0, 4'd0, "Ne", "w "));
    send_item(make_group(GRP_RADIOTEXT, 1'b0, 1'b1, 4'd2, "ab", "cd"));
    send_item(make_group(GRP_RADIOTEXT, 1'b0, 1'b1, 4'd1, "xy", "z!"));
  endtask

  task automatic test_stream_names();
    in_item_t it;
    set_stream_mode(1'b1);
    for (int seg = 0; seg < 4; seg++) begin
      it       = make_group(GRP_BASIC, 1'b1, 1'b0, 4'(seg + 4), 16'h0000, 16'h4142 + 16'(seg));
      it.err_d = 2'(seg % 3);
      send_item(it);
    end
  endtask

  task automatic test_random_groups(int count);
    logic [63:0] names [3];
    logic [63:0] station;
    int unsigned pick;
    int unsigned name_sel;
    int          name_seg;
    logic [3:0]  text_seg;
    logic        text_ab;
    in_item_t    it;
    names[0] = "RADIO 1 ";
    names[1] = "NEWS 24 ";
    names[2] = "JAZZ FM ";
    name_sel = 0;
    name_seg = 0;
    text_seg = 4'd0;
    text_ab  = 1'b0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if (name_seg == 0 && $urandom_range(0, 3) == 0) name_sel = $urandom_range(0, 2);
        station  = names[2'(name_sel)];
        it       = make_group(GRP_BASIC, 1'($urandom), 1'($urandom),
                              {2'($urandom), 2'(name_seg)}, 16'($urandom),
                              station[63 - 16 * name_seg -: 16]);
        name_seg = (name_seg + 1) % 4;
      end else if (pick < 75) begin
        it = make_group(GRP_RADIOTEXT, 1'b0, text_ab, text_seg, 16'($urandom), 16'($urandom));
        if (text_seg == 4'd15 || $urandom_range(0, 7) == 0) text_seg = 4'($urandom_range(0, 3));
        else text_seg = text_seg + 4'd1;
        if ($urandom_range(0, 15) == 0) text_ab = ~text_ab;
      end else begin
        it.action  = (pick < 80) || ($urandom_range(0, 7) == 0);
        it.block_a = 16'($urandom);
        it.block_b = 16'($urandom);
        it.block_c = 16'($urandom);
        it.block_d = 16'($urandom);
      end
      if (pick < 75) begin
        it.err_a = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'd0;
        it.err_b = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'd0;
        it.err_d = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'd0;
      end else begin
        it.err_a = 2'($urandom);
        it.err_b = 2'($urandom);
        it.err_d = 2'($urandom);
      end
      send_item(it);
    end
  endtask

  task automatic test_output_holdoff();
    wait_idle();
    idling          = 1'b0;
    holdoff_request = HOLD_OFF_CYCLES;
    for (int n = 0; n < 12; n++) begin
      send_item(make_group(4'(n), 1'($urandom), 1'b0, 4'(n), 16'($urandom), 16'($urandom)));
    end
    wait_idle();
    idling = 1'b1;
  endtask

  initial begin : result_side
    int unsigned pause;
    pause = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        check_result(out_data);
        if (idling) pause = $urandom_range(0, 10);
      end
      if (holdoff_request > 0) begin
        holdoff_request--;
        out_stall <= 1'b1;
      end else if (pause > 0) begin
        pause--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    stream_mode = 1'b0;
    clear_decoded();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_program_fields();
    test_name_voting();
    test_radiotext();
    test_stream_names();
    set_stream_mode(1'b0);
    test_random_groups(60);
    set_stream_mode(1'b1);
    test_random_groups(40);
    set_stream_mode(1'b0);
    idling = 1'b0;
    test_random_groups(30);
    idling = 1'b1;
    test_output_holdoff();
    wait_idle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
